// ----- sv/dpwp_pkg.sv -----
`default_nettype none
package dpwp_pkg;
    localparam int COORD_BITS_DEF = 12;

    localparam logic [2:0] REG_CENTER_X = 3'd0;
    localparam logic [2:0] REG_CENTER_Y = 3'd1;
    localparam logic [2:0] REG_INV_FX   = 3'd2;
    localparam logic [2:0] REG_INV_FY   = 3'd3;
    localparam logic [2:0] REG_INV_DS   = 3'd4;

    localparam logic FUNC_PIXEL = 1'b0;
    localparam logic FUNC_POSE  = 1'b1;

    localparam logic [15:0] CX_RESET  = 16'd5208;
    localparam logic [15:0] CY_RESET  = 16'd4056;
    localparam logic [31:0] IFX_RESET = 32'd32388;
    localparam logic [31:0] IFY_RESET = 32'd32326;
    localparam logic [31:0] IDS_RESET = 32'd16777;
    localparam logic signed [31:0] Q_ONE = 32'sh4000_0000;

    typedef struct packed {
        logic [15:0] dx_mag;
        logic        dx_neg;
        logic [15:0] dy_mag;
        logic        dy_neg;
        logic [15:0] depth;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } t_pix;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647)       sat32 = 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648) sat32 = 32'sh8000_0000;
        else                           sat32 = v[31:0];
    endfunction
endpackage
`default_nettype wire

// ----- sv/depth_pixel_to_world_point.sv -----
// channel | valid    | stall   | payload
// input   | i_valid  | o_stall | i_func .. i_pose_value
// output  | o_valid  | i_stall | o_world_x .. o_blue_out
// config  | i_cfg_we | none    | i_cfg_index, i_cfg_data
// One transaction per cycle while o_stall is low; pixels of zero depth are dropped before the queue.
// A pose transaction waits until the queue and the back pipeline are empty.
// A quaternion write stalls input while the matrix rebuilds on one multiplier.
// Reset is synchronous, active low; control, config and pose registers return to their reset values.
// An output stall with o_valid high freezes the back pipeline; the queue keeps taking input until full.
`default_nettype none
module depth_pixel_to_world_point #(
    parameter int COORD_BITS = dpwp_pkg::COORD_BITS_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    output logic               o_stall,
    input  wire                i_func,
    input  wire         [11:0] i_col,
    input  wire         [11:0] i_row,
    input  wire         [15:0] i_raw_depth,
    input  wire         [7:0]  i_blue_in,
    input  wire         [7:0]  i_green_in,
    input  wire         [7:0]  i_red_in,
    input  wire         [2:0]  i_pose_slot,
    input  wire signed  [31:0] i_pose_value,
    output logic               o_valid,
    input  wire                i_stall,
    output logic signed [31:0] o_world_x,
    output logic signed [31:0] o_world_y,
    output logic signed [31:0] o_world_z,
    output logic        [7:0]  o_red_out,
    output logic        [7:0]  o_green_out,
    output logic        [7:0]  o_blue_out,
    input  wire                i_cfg_we,
    input  wire         [2:0]  i_cfg_index,
    input  wire         [31:0] i_cfg_data
);
    logic [15:0] r_cx, r_cy;
    logic [31:0] r_ifx, r_ify, r_ids;
    logic w_push, w_qrdy, w_qv, w_pop, w_pwe, w_busy, w_rebuild;
    dpwp_pkg::t_pix w_qin, w_qout;
    logic [2:0] w_pslot;
    logic signed [31:0] w_pval;
    logic signed [31:0] w_rot [9];
    logic signed [31:0] w_tr [3];

    // hold pose writes until nothing is in flight; hold everything during a rebuild or while the queue is full
    assign o_stall = !w_qrdy || w_rebuild || ((i_func == dpwp_pkg::FUNC_POSE) && w_busy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= dpwp_pkg::CX_RESET;
            r_cy <= dpwp_pkg::CY_RESET;
            r_ifx <= dpwp_pkg::IFX_RESET;
            r_ify <= dpwp_pkg::IFY_RESET;
            r_ids <= dpwp_pkg::IDS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dpwp_pkg::REG_CENTER_X: r_cx <= i_cfg_data[15:0];
                dpwp_pkg::REG_CENTER_Y: r_cy <= i_cfg_data[15:0];
                dpwp_pkg::REG_INV_FX:   r_ifx <= i_cfg_data;
                dpwp_pkg::REG_INV_FY:   r_ify <= i_cfg_data;
                dpwp_pkg::REG_INV_DS:   r_ids <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dpwp_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_valid, .i_func, .i_col, .i_row, .i_raw_depth,
        .i_blue_in, .i_green_in, .i_red_in, .i_pose_slot, .i_pose_value,
        .i_cx(r_cx), .i_cy(r_cy), .i_q_ready(!o_stall),
        .o_q_push(w_push), .o_q_data(w_qin),
        .o_pose_we(w_pwe), .o_pose_slot(w_pslot), .o_pose_value(w_pval)
    );

    dpwp_fifo u_fifo (
        .i_clk, .i_rst_n, .i_push(w_push), .i_data(w_qin), .o_ready(w_qrdy),
        .o_valid(w_qv), .o_data(w_qout), .i_pop(w_pop)
    );

    dpwp_pose u_pose (
        .i_clk, .i_rst_n, .i_we(w_pwe), .i_slot(w_pslot), .i_value(w_pval),
        .o_rot(w_rot), .o_trans(w_tr), .o_busy(w_rebuild)
    );

    dpwp_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_qv), .i_data(w_qout), .o_pop(w_pop),
        .i_ifx(r_ifx), .i_ify(r_ify), .i_ids(r_ids), .i_rot(w_rot), .i_trans(w_tr),
        .i_stall, .o_valid, .o_world_x, .o_world_y, .o_world_z,
        .o_red_out, .o_green_out, .o_blue_out, .o_busy(w_busy)
    );

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_world_x)) else $error("output lost");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_qrdy) else $error("queue overflow");
    a_pop_has: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_qv) else $error("queue underflow");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> w_busy) else $error("busy flag wrong");
endmodule
`default_nettype wire

// ----- sv/dpwp_front.sv -----
`default_nettype none
module dpwp_front #(
    parameter int COORD_BITS = dpwp_pkg::COORD_BITS_DEF
) (
    input  wire               i_valid,
    input  wire               i_func,
    input  wire        [11:0] i_col,
    input  wire        [11:0] i_row,
    input  wire        [15:0] i_raw_depth,
    input  wire        [7:0]  i_blue_in,
    input  wire        [7:0]  i_green_in,
    input  wire        [7:0]  i_red_in,
    input  wire        [2:0]  i_pose_slot,
    input  wire signed [31:0] i_pose_value,
    input  wire        [15:0] i_cx,
    input  wire        [15:0] i_cy,
    input  wire               i_q_ready,
    output logic              o_q_push,
    output dpwp_pkg::t_pix    o_q_data,
    output logic              o_pose_we,
    output logic       [2:0]  o_pose_slot,
    output logic signed [31:0] o_pose_value
);
    localparam logic [11:0] CMASK = 12'((1 << COORD_BITS) - 1);

    logic [16:0] w_px, w_py;
    logic signed [17:0] w_dx, w_dy;
    logic w_take;

    assign w_take = i_valid && i_q_ready;
    assign w_px = {1'b0, 16'(i_col & CMASK) << 4};
    assign w_py = {1'b0, 16'(i_row & CMASK) << 4};
    assign w_dx = $signed({1'b0, w_px}) - $signed({2'b0, i_cx});
    assign w_dy = $signed({1'b0, w_py}) - $signed({2'b0, i_cy});

    always_comb begin
        o_q_push = w_take && (i_func == dpwp_pkg::FUNC_PIXEL) && (i_raw_depth != 16'd0);
        o_q_data.dx_neg = w_dx[17];
        o_q_data.dx_mag = w_dx[17] ? 16'(-w_dx) : w_dx[15:0];
        o_q_data.dy_neg = w_dy[17];
        o_q_data.dy_mag = w_dy[17] ? 16'(-w_dy) : w_dy[15:0];
        o_q_data.depth = i_raw_depth;
        o_q_data.red = i_red_in;
        o_q_data.green = i_green_in;
        o_q_data.blue = i_blue_in;
        o_pose_we = w_take && (i_func == dpwp_pkg::FUNC_POSE);
        o_pose_slot = i_pose_slot;
        o_pose_value = i_pose_value;
    end
endmodule
`default_nettype wire

// ----- sv/dpwp_fifo.sv -----
`default_nettype none
module dpwp_fifo (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_push,
    input  dpwp_pkg::t_pix i_data,
    output logic           o_ready,
    output logic           o_valid,
    output dpwp_pkg::t_pix o_data,
    input  wire            i_pop
);
    dpwp_pkg::t_pix r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;

    assign o_ready = (r_cnt != 3'd4);
    assign o_valid = (r_cnt != 3'd0);
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 2'd1;
            if (i_pop) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(i_push) - 3'(i_pop);
        end
    end
endmodule
`default_nettype wire

// ----- sv/dpwp_pose.sv -----
`default_nettype none
module dpwp_pose (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_we,
    input  wire         [2:0]  i_slot,
    input  wire signed  [31:0] i_value,
    output logic signed [31:0] o_rot [9],
    output logic signed [31:0] o_trans [3],
    output logic               o_busy
);
    logic signed [31:0] r_q [4];
    logic signed [31:0] r_t [3];
    logic signed [31:0] r_rot [9];
    logic [3:0] r_step;
    logic signed [31:0] r_qa, r_qb;
    logic signed [63:0] r_prod;
    logic signed [34:0] r_tp [10];
    logic [3:0] n_step;
    logic [1:0] w_ia, w_ib;
    logic signed [63:0] w_two;

    // product order: xx yy zz xy zw xz yw yz xw
    always_comb begin
        case (r_step)
            4'd1: begin w_ia = 2'd0; w_ib = 2'd0; end
            4'd2: begin w_ia = 2'd1; w_ib = 2'd1; end
            4'd3: begin w_ia = 2'd2; w_ib = 2'd2; end
            4'd4: begin w_ia = 2'd0; w_ib = 2'd1; end
            4'd5: begin w_ia = 2'd2; w_ib = 2'd3; end
            4'd6: begin w_ia = 2'd0; w_ib = 2'd2; end
            4'd7: begin w_ia = 2'd1; w_ib = 2'd3; end
            4'd8: begin w_ia = 2'd1; w_ib = 2'd2; end
            4'd9: begin w_ia = 2'd0; w_ib = 2'd3; end
            default: begin w_ia = 2'd0; w_ib = 2'd0; end
        endcase
        w_two = (r_prod + 64'sd268435456) >>> 29;
        n_step = r_step;
        if (r_step != 4'd0) n_step = (r_step == 4'd11) ? 4'd0 : r_step + 4'd1;
        if (i_we && i_slot < 3'd4) n_step = 4'd1;
    end

    always_ff @(posedge i_clk) begin
        r_qa <= r_q[w_ia];
        r_qb <= r_q[w_ib];
        r_prod <= 64'(r_qa) * 64'(r_qb);
        if (r_step >= 4'd3 && r_step <= 4'd11) r_tp[r_step - 4'd2] <= w_two[34:0];
        if (!i_rst_n) begin
            r_q[0] <= '0; r_q[1] <= '0; r_q[2] <= '0; r_q[3] <= dpwp_pkg::Q_ONE;
            r_t[0] <= '0; r_t[1] <= '0; r_t[2] <= '0;
            for (int k = 0; k < 9; k++)
                r_rot[k] <= (k == 0 || k == 4 || k == 8) ? dpwp_pkg::Q_ONE : '0;
            r_step <= '0;
        end else begin
            r_step <= n_step;
            if (i_we && i_slot < 3'd4) r_q[i_slot[1:0]] <= i_value;
            else if (i_we && i_slot < 3'd7) r_t[2'(i_slot - 3'd4)] <= i_value;
            if (r_step == 4'd11) begin
                r_rot[0] <= dpwp_pkg::sat32(64'(dpwp_pkg::Q_ONE) - 64'(r_tp[2]) - 64'(r_tp[3]));
                r_rot[1] <= dpwp_pkg::sat32(64'(r_tp[4]) - 64'(r_tp[5]));
                r_rot[2] <= dpwp_pkg::sat32(64'(r_tp[6]) + 64'(r_tp[7]));
                r_rot[3] <= dpwp_pkg::sat32(64'(r_tp[4]) + 64'(r_tp[5]));
                r_rot[4] <= dpwp_pkg::sat32(64'(dpwp_pkg::Q_ONE) - 64'(r_tp[1]) - 64'(r_tp[3]));
                r_rot[5] <= dpwp_pkg::sat32(64'(r_tp[8]) - w_two);
                r_rot[6] <= dpwp_pkg::sat32(64'(r_tp[6]) - 64'(r_tp[7]));
                r_rot[7] <= dpwp_pkg::sat32(64'(r_tp[8]) + w_two);
                r_rot[8] <= dpwp_pkg::sat32(64'(dpwp_pkg::Q_ONE) - 64'(r_tp[1]) - 64'(r_tp[2]));
            end
        end
    end

    assign o_rot = r_rot;
    assign o_trans = r_t;
    assign o_busy = (r_step != 4'd0);
endmodule
`default_nettype wire

// ----- sv/dpwp_back.sv -----
`default_nettype none
module dpwp_back (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_valid,
    input  dpwp_pkg::t_pix     i_data,
    output logic               o_pop,
    input  wire         [31:0] i_ifx,
    input  wire         [31:0] i_ify,
    input  wire         [31:0] i_ids,
    input  wire signed  [31:0] i_rot [9],
    input  wire signed  [31:0] i_trans [3],
    input  wire                i_stall,
    output logic               o_valid,
    output logic signed [31:0] o_world_x,
    output logic signed [31:0] o_world_y,
    output logic signed [31:0] o_world_z,
    output logic        [7:0]  o_red_out,
    output logic        [7:0]  o_green_out,
    output logic        [7:0]  o_blue_out,
    output logic               o_busy
);
    localparam int NS = 8;
    logic [NS-1:0] r_v;
    logic w_adv;
    logic [23:0] r_col [NS];
    // stage 1
    logic [47:0] r1_dz;
    logic [15:0] r1_mx, r1_my;
    logic r1_nx, r1_ny;
    // stage 2
    logic [30:0] r2_z;
    logic [15:0] r2_mx, r2_my;
    logic r2_nx, r2_ny;
    // stage 3: |d|*z
    logic [46:0] r3_ax, r3_ay;
    logic [30:0] r3_z;
    logic r3_nx, r3_ny;
    // stage 4: partial products with inv_f
    logic [46:0] r4_hx, r4_hy;
    logic [63:0] r4_lx, r4_ly;
    logic [30:0] r4_z;
    logic r4_nx, r4_ny;
    // stage 5: camera point
    logic signed [31:0] r5_p [3];
    // stage 6: nine products
    logic signed [63:0] r6_m [9];
    // stage 7: sums
    logic signed [63:0] r7_acc [3];
    logic signed [31:0] r8_w [3];
    logic [47:0] w_z1;
    logic [51:0] w_rx, w_ry;
    logic signed [63:0] w_acc [3];

    assign w_adv = !(r_v[NS-1] && i_stall);
    assign o_pop = w_adv && i_valid;
    assign o_busy = i_valid || (r_v != '0);

    function automatic logic signed [31:0] lat(input logic [51:0] r, input logic neg);
        if (!neg) lat = (r > 52'd2147483647) ? 32'sh7FFF_FFFF : 32'(r);
        else if (r > 52'd2147483648) lat = 32'sh8000_0000;
        else lat = 32'(-$signed({1'b0, r}));
    endfunction

    always_comb begin
        w_z1 = (r1_dz + 48'd128) >> 8;
        w_rx = 52'({r4_hx, 4'b0}) + 52'((r4_lx + 64'd134217728) >> 28);
        w_ry = 52'({r4_hy, 4'b0}) + 52'((r4_ly + 64'd134217728) >> 28);
        for (int i = 0; i < 3; i++)
            w_acc[i] = (64'(i_trans[i]) <<< 16) + (r6_m[3*i] >>> 14)
                     + (r6_m[3*i+1] >>> 14) + (r6_m[3*i+2] >>> 14);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_col[0] <= {i_data.red, i_data.green, i_data.blue};
            for (int k = 1; k < NS; k++) r_col[k] <= r_col[k-1];
            r1_dz <= 48'(i_data.depth) * 48'(i_ids);
            r1_mx <= i_data.dx_mag; r1_nx <= i_data.dx_neg;
            r1_my <= i_data.dy_mag; r1_ny <= i_data.dy_neg;
            r2_z <= (w_z1 > 48'd2147483647) ? 31'h7FFF_FFFF : w_z1[30:0];
            r2_mx <= r1_mx; r2_nx <= r1_nx; r2_my <= r1_my; r2_ny <= r1_ny;
            r3_ax <= 47'(r2_mx) * 47'(r2_z);
            r3_ay <= 47'(r2_my) * 47'(r2_z);
            r3_z <= r2_z; r3_nx <= r2_nx; r3_ny <= r2_ny;
            r4_hx <= 47'(r3_ax[46:32]) * 47'(i_ifx);
            r4_lx <= 64'(r3_ax[31:0]) * 64'(i_ifx);
            r4_hy <= 47'(r3_ay[46:32]) * 47'(i_ify);
            r4_ly <= 64'(r3_ay[31:0]) * 64'(i_ify);
            r4_z <= r3_z; r4_nx <= r3_nx; r4_ny <= r3_ny;
            r5_p[0] <= lat(w_rx, r4_nx);
            r5_p[1] <= lat(w_ry, r4_ny);
            r5_p[2] <= $signed({1'b0, r4_z});
            for (int i = 0; i < 9; i++) r6_m[i] <= 64'(i_rot[i]) * 64'(r5_p[i%3]);
            for (int i = 0; i < 3; i++) begin
                r7_acc[i] <= w_acc[i];
                r8_w[i] <= dpwp_pkg::sat32((r7_acc[i] + 64'sd32768) >>> 16);
            end
        end
        if (!i_rst_n) r_v <= '0;
        else if (w_adv) r_v <= {r_v[NS-2:0], i_valid};
    end

    assign o_valid = r_v[NS-1];
    assign o_world_x = r8_w[0];
    assign o_world_y = r8_w[1];
    assign o_world_z = r8_w[2];
    assign o_red_out = r_col[NS-1][23:16];
    assign o_green_out = r_col[NS-1][15:8];
    assign o_blue_out = r_col[NS-1][7:0];
endmodule
`default_nettype wire
